// ===== design/utf8_stream_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTF8SD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types, codes, the byte class function and the transition table of the automaton.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int CODE_POINT_W = 21;
	localparam int CHAR_COUNT_W = 32;
	localparam int DFA_STATE_W  = 4;
	localparam int CLASS_W      = 4;

	localparam logic [DFA_STATE_W-1:0] DFA_ACCEPT   = 4'd0;
	localparam logic [DFA_STATE_W-1:0] DFA_REJECT   = 4'd1;
	localparam logic [DFA_STATE_W-1:0] DFA_LAST_ST  = 4'd8;

	typedef enum logic [1:0] {
		STATUS_VALID   = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_TRUNC   = 2'd2
	} status_t;

	typedef struct packed {
		logic [DFA_STATE_W-1:0]  dfa_state;
		logic [CODE_POINT_W-1:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic                    string_done;
		logic [CHAR_COUNT_W-1:0] char_count;
		status_t                 status;
		logic [CODE_POINT_W-1:0] code_point;
	} dec_result_t;

	localparam logic [3:0] TRANS_TBL [0:143] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
		4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
		4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
	};

	function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
		logic [CLASS_W-1:0] cls;
		if (b <= 8'h7F) begin
			cls = 4'd0;
		end else if (b <= 8'h8F) begin
			cls = 4'd1;
		end else if (b <= 8'h9F) begin
			cls = 4'd9;
		end else if (b <= 8'hBF) begin
			cls = 4'd7;
		end else if (b <= 8'hC1) begin
			cls = 4'd8;
		end else if (b <= 8'hDF) begin
			cls = 4'd2;
		end else if (b == 8'hE0) begin
			cls = 4'd10;
		end else if (b == 8'hED) begin
			cls = 4'd4;
		end else if (b <= 8'hEF) begin
			cls = 4'd3;
		end else if (b == 8'hF0) begin
			cls = 4'd11;
		end else if (b <= 8'hF3) begin
			cls = 4'd6;
		end else if (b == 8'hF4) begin
			cls = 4'd5;
		end else begin
			cls = 4'd8;
		end
		return cls;
	endfunction

endpackage

// ===== design/utf8sd_step.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Advances the automaton, the partial code point and the count by one byte.
// ----------------------------------------------------------------------------
module utf8sd_step #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                       sticky,
	input  utf8sd_pkg::dec_state_t     st,
	input  logic [COUNT_WIDTH-1:0]     count,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_string,
	output utf8sd_pkg::dec_state_t     st_next,
	output logic [COUNT_WIDTH-1:0]     count_next,
	output logic                       emit,
	output utf8sd_pkg::dec_result_t    res
);

	logic [utf8sd_pkg::DFA_STATE_W-1:0]  cur;
	logic [utf8sd_pkg::DFA_STATE_W-1:0]  nxt;
	logic [utf8sd_pkg::CLASS_W-1:0]      cls;
	logic [utf8sd_pkg::CODE_POINT_W-1:0] part;
	logic [utf8sd_pkg::CODE_POINT_W-1:0] cp;
	logic [COUNT_WIDTH-1:0]              cnt_upd;
	logic [utf8sd_pkg::CHAR_COUNT_W-1:0] cnt_rep;
	utf8sd_pkg::status_t                 status;

	generate
		if (COUNT_WIDTH > utf8sd_pkg::CHAR_COUNT_W) begin : g_wide
			assign cnt_rep = (|cnt_upd[COUNT_WIDTH-1:utf8sd_pkg::CHAR_COUNT_W]) ?
				'1 : cnt_upd[utf8sd_pkg::CHAR_COUNT_W-1:0];
		end else begin : g_narrow
			assign cnt_rep = utf8sd_pkg::CHAR_COUNT_W'(cnt_upd);
		end
	endgenerate

	always_comb begin
		cur = (st.dfa_state > utf8sd_pkg::DFA_LAST_ST) ? utf8sd_pkg::DFA_REJECT : st.dfa_state;
		if (cur == utf8sd_pkg::DFA_REJECT && !sticky) begin
			cur = utf8sd_pkg::DFA_ACCEPT;
		end
		cls     = utf8sd_pkg::byte_class(data_byte);
		nxt     = st.dfa_state;
		part    = st.partial;
		cp      = '0;
		cnt_upd = count;
		emit    = 1'b0;
		status  = utf8sd_pkg::STATUS_INVALID;
		if (cur == utf8sd_pkg::DFA_REJECT) begin
			emit = end_of_string;
		end else begin
			if (cur != utf8sd_pkg::DFA_ACCEPT) begin
				part = {st.partial[utf8sd_pkg::CODE_POINT_W-7:0], data_byte[5:0]};
			end else begin
				part = utf8sd_pkg::CODE_POINT_W'((8'hFF >> cls) & data_byte);
			end
			nxt = utf8sd_pkg::TRANS_TBL[{cur, cls}];
			if (nxt == utf8sd_pkg::DFA_ACCEPT) begin
				if (count != '1) begin
					cnt_upd = count + COUNT_WIDTH'(1);
				end
				emit   = 1'b1;
				status = utf8sd_pkg::STATUS_VALID;
				cp     = part;
			end else if (nxt == utf8sd_pkg::DFA_REJECT) begin
				emit = 1'b1;
				if (!sticky) begin
					nxt  = utf8sd_pkg::DFA_ACCEPT;
					part = '0;
				end
			end else if (end_of_string) begin
				emit   = 1'b1;
				status = utf8sd_pkg::STATUS_TRUNC;
			end
		end

		res.code_point  = cp;
		res.status      = status;
		res.char_count  = cnt_rep;
		res.string_done = end_of_string;

		if (end_of_string) begin
			st_next.dfa_state = utf8sd_pkg::DFA_ACCEPT;
			st_next.partial   = '0;
			count_next        = '0;
		end else begin
			st_next.dfa_state = nxt;
			st_next.partial   = part;
			count_next        = cnt_upd;
		end
	end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder: one byte per cycle unless stalled. Each byte is held in
// the byte stage, then its result in the result stage; the automaton step is
// combinational around its state register. The input stalls only while a held
// result waits for the receiver. Asynchronous reset clears both stages, the
// automaton and the character count, and sets sticky_reject to 1.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,    // sticky_reject
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // end_of_string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // code_point, char_count, zero pad
	output logic [1:0]  m_axis_tuser,   // status
	output logic        m_axis_tlast    // string_done
);

	`include "utf8_stream_decoder_macros.svh"

	logic                    sticky_reject_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    eos_s1;
	utf8sd_pkg::dec_state_t  st_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic                    out_valid_q;
	utf8sd_pkg::dec_result_t res_q;

	utf8sd_pkg::dec_state_t  st_next;
	logic [COUNT_WIDTH-1:0]  count_next;
	logic                    emit;
	utf8sd_pkg::dec_result_t res;
	logic                    adv;

	utf8sd_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.sticky        (sticky_reject_q),
		.st            (st_q),
		.count         (count_q),
		.data_byte     (byte_s1),
		.end_of_string (eos_s1),
		.st_next       (st_next),
		.count_next    (count_next),
		.emit          (emit),
		.res           (res)
	);

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_reject_q <= 1'b1;
			valid_s1        <= 1'b0;
			st_q            <= '0;
			count_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sticky_reject_q <= cfg_wr_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				st_q    <= st_next;
				count_q <= count_next;
			end
			if (adv) begin
				out_valid_q <= emit;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
		if (adv && emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.char_count, res_q.code_point};
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tlast  = res_q.string_done;

	`UTF8SD_ASSERT_IMP(a_state_range, 1'b1, st_q.dfa_state <= utf8sd_pkg::DFA_LAST_ST,
		"automaton state out of range")
	`UTF8SD_ASSERT_IMP(a_err_cp_zero,
		out_valid_q && res_q.status != utf8sd_pkg::STATUS_VALID,
		res_q.code_point == '0, "error result carries a nonzero code point")
	`UTF8SD_ASSERT_IMP(a_status_code,
		out_valid_q, res_q.status != 2'd3, "undefined status code")
	`UTF8SD_ASSERT_NEXT(a_eos_clears, adv && eos_s1,
		st_q.dfa_state == utf8sd_pkg::DFA_ACCEPT && st_q.partial == '0 && count_q == '0,
		"state not cleared at string end")
	`UTF8SD_ASSERT_NEXT(a_eos_emits, adv && eos_s1,
		out_valid_q && res_q.string_done, "string end gave no final result")

endmodule

// ===== sim/tb_utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 stream decoder
// Feeds directed and random byte strings through the slave stream and checks
// every decoded item on the master stream against a predictor of the
// automaton, under random idling on both sides and both reject modes.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;

	class utf8_scoreboard;
		bit                                  sticky;
		logic [utf8sd_pkg::DFA_STATE_W-1:0]  dfa;
		logic [utf8sd_pkg::CODE_POINT_W-1:0] partial;
		logic [utf8sd_pkg::CHAR_COUNT_W-1:0] chars;
		utf8sd_pkg::dec_result_t             pending_results [$];
		int                                  errors;
		int                                  mismatches;

		function new();
			sticky     = 1'b1;
			dfa        = utf8sd_pkg::DFA_ACCEPT;
			partial    = '0;
			chars      = '0;
			errors     = 0;
			mismatches = 0;
		endfunction

		function logic [3:0] byte_kind(logic [7:0] b);
			if (b < 8'h80) return 4'd0;
			if (b < 8'h90) return 4'd1;
			if (b < 8'hA0) return 4'd9;
			if (b < 8'hC0) return 4'd7;
			if (b < 8'hC2) return 4'd8;
			if (b < 8'hE0) return 4'd2;
			if (b == 8'hE0) return 4'd10;
			if (b == 8'hED) return 4'd4;
			if (b < 8'hF0) return 4'd3;
			if (b == 8'hF0) return 4'd11;
			if (b < 8'hF4) return 4'd6;
			if (b == 8'hF4) return 4'd5;
			return 4'd8;
		endfunction

		// Transition rows, one nibble per byte kind with kind 0 in the lowest bits.
		function logic [63:0] row_of(logic [3:0] st);
			case (st)
				4'd0: return 64'h1111_6411_1785_3210;
				4'd2: return 64'h1111_1101_0111_1101;
				4'd3: return 64'h1111_1121_2111_1121;
				4'd4: return 64'h1111_1111_2111_1111;
				4'd5: return 64'h1111_1121_1111_1121;
				4'd6: return 64'h1111_1131_3111_1111;
				4'd7: return 64'h1111_1131_3111_1131;
				4'd8: return 64'h1111_1111_1111_1131;
				default: return 64'h1111_1111_1111_1111;
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			logic [utf8sd_pkg::DFA_STATE_W-1:0] cur;
			logic [utf8sd_pkg::DFA_STATE_W-1:0] nxt;
			logic [3:0]                         kind;
			logic [63:0]                        row;
			utf8sd_pkg::dec_result_t            res;
			bit                                 emit;
			cur  = dfa;
			emit = 1'b0;
			res  = '0;
			if (cur > utf8sd_pkg::DFA_LAST_ST) cur = utf8sd_pkg::DFA_REJECT;
			if (cur == utf8sd_pkg::DFA_REJECT && !sticky) cur = utf8sd_pkg::DFA_ACCEPT;
			if (cur == utf8sd_pkg::DFA_REJECT) begin
				if (eos) begin
					emit       = 1'b1;
					res.status = utf8sd_pkg::STATUS_INVALID;
				end
			end else begin
				kind = byte_kind(b);
				if (cur != utf8sd_pkg::DFA_ACCEPT) begin
					partial = {partial[utf8sd_pkg::CODE_POINT_W-7:0], b[5:0]};
				end else begin
					partial = utf8sd_pkg::CODE_POINT_W'((8'hFF >> kind) & b);
				end
				row = row_of(cur);
				nxt = row[kind*4 +: 4];
				if (nxt == utf8sd_pkg::DFA_ACCEPT) begin
					if (chars != '1) chars = chars + 32'd1;
					emit           = 1'b1;
					res.status     = utf8sd_pkg::STATUS_VALID;
					res.code_point = partial;
				end else if (nxt == utf8sd_pkg::DFA_REJECT) begin
					emit       = 1'b1;
					res.status = utf8sd_pkg::STATUS_INVALID;
					if (!sticky) begin
						nxt     = utf8sd_pkg::DFA_ACCEPT;
						partial = '0;
					end
				end else if (eos) begin
					emit       = 1'b1;
					res.status = utf8sd_pkg::STATUS_TRUNC;
				end
				dfa = nxt;
			end
			if (emit) begin
				res.char_count  = chars;
				res.string_done = eos;
				pending_results.push_back(res);
				if (eos) begin
					dfa     = utf8sd_pkg::DFA_ACCEPT;
					partial = '0;
					chars   = '0;
				end
			end
		endfunction

		function void check_result(logic [55:0] data, logic [1:0] user, logic last);
			utf8sd_pkg::dec_result_t got;
			utf8sd_pkg::dec_result_t want;
			got.code_point  = data[20:0];
			got.char_count  = data[52:21];
			got.status      = utf8sd_pkg::status_t'(user);
			got.string_done = last;
			if (pending_results.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected item: cp=%h status=%0d count=%0d done=%b",
						got.code_point, got.status, got.char_count, got.string_done);
				end
				return;
			end
			want = pending_results.pop_front();
			if (got.code_point != want.code_point || got.status != want.status ||
			    got.char_count != want.char_count || got.string_done != want.string_done) begin
				errors++;
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected cp=%h status=%0d count=%0d done=%b",
						want.code_point, want.status, want.char_count, want.string_done);
					$display("          actual   cp=%h status=%0d count=%0d done=%b",
						got.code_point, got.status, got.char_count, got.string_done);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_axis_tvalid;
	logic        m_tready;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	utf8_scoreboard sb = new();
	int             send_idle;
	int             recv_idle;
	int             cycles = 0;
	int             bytes_sent;
	logic [7:0]     str_bytes [$];

	utf8_stream_decoder #(
		.COUNT_WIDTH(32)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tlast (s_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_axis_tready) sb.note_byte(s_tdata, s_tlast);
			if (m_axis_tvalid && m_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end
		end
	end

	// Entered and left at a falling edge.
	task automatic send_item(logic [7:0] b, logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_string(bit close);
		for (int i = 0; i < str_bytes.size(); i++) begin
			send_item(str_bytes[i], close && (i == str_bytes.size() - 1));
		end
		str_bytes.delete();
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_sticky(bit v);
		wait_drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		sb.sticky = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_encoded(logic [20:0] cp, int len, int keep);
		logic [7:0] b [4];
		case (len)
			1: b[0] = {1'b0, cp[6:0]};
			2: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			3: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++) str_bytes.push_back(b[i]);
	endtask

	function automatic logic [20:0] random_scalar(int len);
		logic [20:0] cp;
		case (len)
			1: cp = 21'($urandom_range(0, 'h7F));
			2: cp = 21'($urandom_range('h80, 'h7FF));
			3: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h4000;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	task automatic push_char();
		int roll;
		int len;
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			len = $urandom_range(1, 4);
			push_encoded(random_scalar(len), len, len);
		end else if (roll < 88) begin
			str_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (roll < 94) begin
			len = $urandom_range(2, 4);
			push_encoded(random_scalar(len), len, $urandom_range(1, len - 1));
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					str_bytes.push_back(8'hED);
					str_bytes.push_back(8'hA0 + 8'($urandom_range(0, 31)));
					str_bytes.push_back(8'h80 + 8'($urandom_range(0, 63)));
				end
				1: begin
					str_bytes.push_back(8'hE0);
					str_bytes.push_back(8'h80 + 8'($urandom_range(0, 31)));
					str_bytes.push_back(8'h80 + 8'($urandom_range(0, 63)));
				end
				2: begin
					str_bytes.push_back(8'hF4);
					str_bytes.push_back(8'h90 + 8'($urandom_range(0, 47)));
				end
				default: begin
					str_bytes.push_back(8'hC0 + 8'($urandom_range(0, 1)));
					str_bytes.push_back(8'h80 + 8'($urandom_range(0, 63)));
				end
			endcase
		end
	endtask

	task automatic random_phase(int n_items);
		int target;
		int n;
		target = bytes_sent + n_items;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 12);
				repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) push_char();
			end
			send_string(1'b1);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		send_idle   = 28;
		recv_idle   = 70;
		bytes_sent  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_string(1'b1);
		str_bytes = '{8'hED, 8'h9F, 8'hBF, 8'hFF, 8'h41, 8'h42};
		send_string(1'b1);
		str_bytes = '{8'hE2, 8'h82};
		send_string(1'b1);
		write_sticky(1'b0);
		str_bytes = '{8'hC0, 8'h41, 8'h80, 8'hDF, 8'hBF};
		send_string(1'b1);
		write_sticky(1'b1);
		str_bytes = '{8'hF5};
		send_string(1'b0);
		write_sticky(1'b0);
		str_bytes = '{8'h41};
		send_string(1'b1);

		write_sticky(1'b1);
		random_phase(430);
		write_sticky(1'b0);
		send_idle = 70;
		recv_idle = 28;
		random_phase(430);
		write_sticky(1'b1);
		send_idle = 0;
		recv_idle = 0;
		random_phase(440);

		wait_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/utf8sd_pkg.sv
design/utf8sd_step.sv
design/utf8_stream_decoder.sv
sim/tb_utf8_stream_decoder.sv
